@@ hdl/mchr_pkg.sv @@
// Shared types, field widths, codes and reset values of the capture history ring.
package mchr_pkg;

    // Default sizing of the block.
    localparam int STORE_DEPTH_DEF  = 65536;
    localparam int MAX_CHANNELS_DEF = 8;

    // Word field widths.
    localparam int FUNC_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int WINDOW_W   = 17;
    localparam int POS_W      = 16;
    localparam int SEL_W      = 3;
    localparam int FRAMES_W   = 17;

    // Register widths and reset values.
    localparam int CHAN_CNT_W = 4;
    localparam int RING_LEN_W = 17;
    localparam logic [CHAN_CNT_W-1:0] CHAN_CNT_RST = 4'd4;
    localparam logic [RING_LEN_W-1:0] RING_LEN_RST = 17'd57600;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_IDX_CHANNEL_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IDX_RING_LENGTH   = 1'b1;

    // Quotient bits resolved per cycle by the serial divider.
    localparam int DIV_BITS_PER_CYCLE = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_RD_VAL  = 2'd1,
        FUNC_RD_CHAN = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    // Register contents and the ring length write strobe.
    typedef struct packed {
        logic [CHAN_CNT_W-1:0] channel_count;
        logic [RING_LEN_W-1:0] ring_length;
        logic                  ring_wr;
        logic [RING_LEN_W-1:0] ring_wdata;
    } t_cfg;

endpackage

@@ hdl/mchr_if.sv @@
// Word channel interfaces for commands and read results.
interface mchr_cmd_if;
    import mchr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [WINDOW_W-1:0]        window_frames;
    logic [POS_W-1:0]           position;
    logic [SEL_W-1:0]           channel_select;

    modport source (
        output valid, func, sample_value, window_frames, position, channel_select,
        input  ready
    );
    modport sink (
        input  valid, func, sample_value, window_frames, position, channel_select,
        output ready
    );
endinterface

interface mchr_res_if;
    import mchr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] read_value;
    logic [FRAMES_W-1:0]        frames_available;
    logic                       in_range;

    modport source (
        output valid, read_value, frames_available, in_range,
        input  ready
    );
    modport sink (
        input  valid, read_value, frames_available, in_range,
        output ready
    );
endinterface

@@ hdl/multichannel_capture_history_ring.sv @@
// Top level: circular multichannel sample history with recent-window readout.
// A push word is accepted while idle and the next word may follow at once. A read word
// steps through the divider, offset, address, RAM read and wait states to its result
// word, held until the output slot is free; a new word is taken once the result shows.
// Reset (synchronous, active low) clears the pointer, the wrapped flag and output valid,
// returns the sequencer to idle and loads the register reset values.
module multichannel_capture_history_ring #(
    parameter int STORE_DEPTH  = mchr_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHANNELS = mchr_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mchr_cmd_if.sink                        i_cmd,
    mchr_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mchr_pkg::PADDR_W-1:0]    paddr,
    input  logic [mchr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mchr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mchr_pkg::*;

    // Widths that follow from the sizing parameters.
    localparam int LEN_W     = $clog2(STORE_DEPTH + 1);
    localparam int PTR_W     = $clog2(STORE_DEPTH);
    localparam int CH_W      = $clog2(MAX_CHANNELS + 1);
    localparam int LM_W      = (LEN_W > RING_LEN_W) ? LEN_W : RING_LEN_W;
    localparam int CC_W      = (CH_W > CHAN_CNT_W) ? CH_W : CHAN_CNT_W;
    localparam int SC_W      = (CH_W > SEL_W) ? CH_W : SEL_W;
    localparam int FW_W      = (LEN_W > WINDOW_W) ? LEN_W : WINDOW_W;
    localparam int CP_W      = WINDOW_W + CH_W;
    localparam int EP_W      = POS_W + CH_W + 1;
    localparam int PC_W      = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int PF_W      = (FRAMES_W > POS_W) ? FRAMES_W : POS_W;

    // One-hot sequencer for the read path.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_CALC = 7'b0000100,
        S_ADDR = 7'b0001000,
        S_RD   = 7'b0010000,
        S_WAIT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_cfg                  w_cfg;
    t_state                r_state;
    t_state                n_state;
    t_func                 w_func;

    // Ring control state.
    logic [PTR_W-1:0]      r_wp;
    logic                  r_wrapped;

    // Effective ring length and channel count.
    logic [LEN_W-1:0]      w_len;
    logic [LEN_W-1:0]      w_new_len;
    logic [LEN_W:0]        w_wp_inc;
    logic [CH_W-1:0]       w_chans;

    // Read word being served.
    t_func                 r_func;
    logic [WINDOW_W-1:0]   r_window;
    logic [POS_W-1:0]      r_pos;
    logic [SEL_W-1:0]      r_sel;
    logic [CH_W-1:0]       r_chans;
    logic                  r_act;
    logic [FRAMES_W-1:0]   r_frames;
    logic [LEN_W-1:0]      r_copy;
    logic [LEN_W-1:0]      r_elem;
    logic [LEN_W-1:0]      r_start;
    logic                  r_ok;
    logic [SAMPLE_W-1:0]   r_value;

    // Output slot.
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_out_value;
    logic [FRAMES_W-1:0]   r_out_frames;
    logic                  r_out_ok;

    logic                  w_accept;
    logic                  w_push;
    logic                  w_rd_start;
    logic                  w_act;
    logic [LEN_W-1:0]      w_valid_cnt;
    logic                  w_div_done;
    logic [LEN_W-1:0]      w_quot;
    logic [FW_W-1:0]       w_quot_ext;
    logic [FW_W-1:0]       w_win_ext;
    logic [CP_W-1:0]       w_copy_full;
    logic [EP_W-1:0]       w_elem_full;
    logic [LEN_W:0]        w_start_full;
    logic [LEN_W:0]        w_idx_sum;
    logic [LEN_W:0]        w_idx;
    logic                  w_ok;
    logic                  w_ram_we;
    logic [PTR_W-1:0]      w_ram_addr;
    logic [SAMPLE_W-1:0]   w_ram_rdata;
    logic                  w_out_free;

    mchr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // A ring length of zero behaves as one; anything beyond the memory is clamped.
    always_comb begin
        if (w_cfg.ring_length == '0) begin
            w_len = LEN_W'(1);
        end else if (LM_W'(w_cfg.ring_length) > LM_W'(STORE_DEPTH)) begin
            w_len = LEN_W'(STORE_DEPTH);
        end else begin
            w_len = LEN_W'(w_cfg.ring_length);
        end

        if (w_cfg.ring_wdata == '0) begin
            w_new_len = LEN_W'(1);
        end else if (LM_W'(w_cfg.ring_wdata) > LM_W'(STORE_DEPTH)) begin
            w_new_len = LEN_W'(STORE_DEPTH);
        end else begin
            w_new_len = LEN_W'(w_cfg.ring_wdata);
        end
    end

    // Channel counts above the supported maximum saturate.
    always_comb begin
        if (CC_W'(w_cfg.channel_count) > CC_W'(MAX_CHANNELS)) begin
            w_chans = CH_W'(MAX_CHANNELS);
        end else begin
            w_chans = CH_W'(w_cfg.channel_count);
        end
    end

    assign w_func     = t_func'(i_cmd.func);
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_push     = w_accept && (w_func == FUNC_PUSH);
    assign w_rd_start = w_accept && (w_func inside {FUNC_RD_VAL, FUNC_RD_CHAN});
    assign w_wp_inc   = (LEN_W + 1)'(r_wp) + 1'b1;

    // Only a non-empty window on a real channel can yield whole frames.
    assign w_act = (w_chans != '0) && (i_cmd.window_frames != '0) &&
                   !((w_func == FUNC_RD_CHAN) && (SC_W'(i_cmd.channel_select) >= SC_W'(w_chans)));

    // Valid samples are the whole ring once it has wrapped.
    assign w_valid_cnt = r_wrapped ? w_len : LEN_W'(r_wp);

    // Whole frames in the valid data; the window is then clipped to this.
    mchr_div #(
        .DVD_W (LEN_W),
        .DVS_W (CH_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rd_start),
        .i_dividend (w_valid_cnt),
        .i_divisor  (w_chans),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_quot_ext = FW_W'(w_quot);
    assign w_win_ext  = FW_W'(r_window);

    // Trimmed sample count and the element offset inside the window.
    assign w_copy_full = CP_W'(r_frames) * CP_W'(r_chans);
    assign w_elem_full = EP_W'(r_pos) * EP_W'(r_chans) + EP_W'(r_sel);

    // The window starts copy samples behind the write pointer, modulo the length.
    always_comb begin
        if (LEN_W'(r_wp) >= r_copy) begin
            w_start_full = (LEN_W + 1)'(r_wp) - (LEN_W + 1)'(r_copy);
        end else begin
            w_start_full = (LEN_W + 1)'(r_wp) + (LEN_W + 1)'(w_len) - (LEN_W + 1)'(r_copy);
        end
    end

    always_comb begin
        if (r_func == FUNC_RD_VAL) begin
            w_ok = (r_frames != '0) && (PC_W'(r_pos) < PC_W'(r_copy));
        end else begin
            w_ok = (r_frames != '0) && (PF_W'(r_pos) < PF_W'(r_frames));
        end
    end

    // Element address folded back into the ring.
    always_comb begin
        w_idx_sum = (LEN_W + 1)'(r_start) + (LEN_W + 1)'(r_elem);
        if (w_idx_sum >= (LEN_W + 1)'(w_len)) begin
            w_idx = w_idx_sum - (LEN_W + 1)'(w_len);
        end else begin
            w_idx = w_idx_sum;
        end
    end

    // The single memory port serves pushes in idle and the one read of a read word.
    assign w_ram_we   = w_push;
    assign w_ram_addr = (r_state == S_RD) ? PTR_W'(w_idx) : r_wp;

    mchr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (i_cmd.sample_value),
        .o_rdata (w_ram_rdata)
    );

    assign w_out_free = !r_out_valid || o_res.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_rd_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: n_state = S_ADDR;
            S_ADDR: n_state = S_RD;
            S_RD:   n_state = S_WAIT;
            S_WAIT: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, write pointer, wrapped flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Shrinking the ring to or below the pointer wraps it, keeping the contents.
            if (w_cfg.ring_wr) begin
                if (LEN_W'(r_wp) >= w_new_len) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end
            end else if (w_push) begin
                if (w_wp_inc >= (LEN_W + 1)'(w_len)) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= PTR_W'(w_wp_inc);
                end
            end

            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Read path payload registers.
    always_ff @(posedge i_clk) begin
        if (w_rd_start) begin
            r_func   <= w_func;
            r_window <= i_cmd.window_frames;
            r_pos    <= i_cmd.position;
            r_sel    <= i_cmd.channel_select;
            r_chans  <= w_chans;
            r_act    <= w_act;
        end

        if ((r_state == S_DIV) && w_div_done) begin
            if (!r_act) begin
                r_frames <= '0;
            end else if (w_win_ext < w_quot_ext) begin
                r_frames <= r_window;
            end else begin
                r_frames <= FRAMES_W'(w_quot_ext);
            end
        end

        if (r_state == S_CALC) begin
            r_copy <= LEN_W'(w_copy_full);
            if (r_func == FUNC_RD_VAL) begin
                r_elem <= LEN_W'(r_pos);
            end else begin
                r_elem <= LEN_W'(w_elem_full);
            end
        end

        if (r_state == S_ADDR) begin
            r_start <= LEN_W'(w_start_full);
            r_ok    <= w_ok;
        end

        if (r_state == S_WAIT) begin
            r_value <= r_ok ? w_ram_rdata : '0;
        end

        if ((r_state == S_OUT) && w_out_free) begin
            r_out_value  <= r_value;
            r_out_frames <= r_frames;
            r_out_ok     <= r_ok;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.read_value       = r_out_value;
    assign o_res.frames_available = r_out_frames;
    assign o_res.in_range         = r_out_ok;
endmodule

@@ hdl/mchr_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module mchr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/mchr_cfg.sv @@
// APB register file holding the channel count and the ring length.
module mchr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mchr_pkg::PADDR_W-1:0]     paddr,
    input  logic [mchr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mchr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output mchr_pkg::t_cfg                   o_cfg
);
    import mchr_pkg::*;

    logic [CHAN_CNT_W-1:0] r_channel_count;
    logic [RING_LEN_W-1:0] r_ring_length;
    logic [REG_IDX_W-1:0]  w_idx;
    logic                  w_wr;

    // Byte addresses are word aligned; the low two bits are ignored.
    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CHAN_CNT_RST;
            r_ring_length   <= RING_LEN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_IDX_CHANNEL_COUNT: begin
                    r_channel_count <= pwdata[CHAN_CNT_W-1:0];
                end
                REG_IDX_RING_LENGTH: begin
                    r_ring_length <= pwdata[RING_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_IDX_CHANNEL_COUNT: prdata = APB_DATA_W'(r_channel_count);
            REG_IDX_RING_LENGTH:   prdata = APB_DATA_W'(r_ring_length);
            default:               prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.channel_count = r_channel_count;
        o_cfg.ring_length   = r_ring_length;
        o_cfg.ring_wr       = w_wr && (w_idx == REG_IDX_RING_LENGTH);
        o_cfg.ring_wdata    = pwdata[RING_LEN_W-1:0];
    end
endmodule

@@ hdl/mchr_div.sv @@
// Serial restoring divider for the valid sample count over the channel count.
module mchr_div #(
    parameter int DVD_W = 17,
    parameter int DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    import mchr_pkg::*;

    localparam int STEPS = (DVD_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int PAD_W = STEPS * DIV_BITS_PER_CYCLE;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] r_quo;
    logic [PAD_W-1:0] n_quo;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W:0]   n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        for (int b = 0; b < DIV_BITS_PER_CYCLE; b++) begin
            n_rem = {n_rem[DVS_W-1:0], n_quo[PAD_W-1]};
            n_quo = {n_quo[PAD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem    = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= PAD_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[DVD_W-1:0];
endmodule
